/* sv/sine_taylor_series_core_defines.svh */
// Assertion macros shared by the sine Taylor series core.
`ifndef SINE_TAYLOR_SERIES_CORE_DEFINES_SVH
`define SINE_TAYLOR_SERIES_CORE_DEFINES_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define STS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define STS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/sts_pkg.sv */
// Types and constants of the sine Taylor series core.
`timescale 1ns / 1ps

package sts_pkg;

  localparam int ANGLE_W = 19;
  localparam int SINE_W = 18;
  localparam int RECIP_ENTRIES = 40;
  localparam int RECIP_W = 30;
  localparam int IDX_W = 6;
  localparam int MAG_W = 18;
  localparam int TERM_W = 32;
  localparam int PROD_W = 64;
  localparam int SUM_W = 34;

  localparam logic signed [ANGLE_W-1:0] PI_Q16 = 19'sd205887;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Reciprocals of (2i)(2i+1) in Q32, rounded half up; entry zero is unused.
  localparam logic [RECIP_W-1:0] RECIP_TABLE [0:RECIP_ENTRIES-1] = '{
    30'd0,        30'd715827883, 30'd214748365, 30'd102261126, 30'd59652324,
    30'd39045157, 30'd27531842,  30'd20452225,  30'd15790321,  30'd12558384,
    30'd10226113, 30'd8488078,   30'd7158279,   30'd6118187,   30'd5289369,
    30'd4618244,  30'd4067204,   30'd3609216,   30'd3224450,   30'd2898089,
    30'd2618882,  30'd2378166,   30'd2169175,   30'd1986571,   30'd1826092,
    30'd1684301,  30'd1558406,   30'd1446117,   30'd1345541,   30'd1255104,
    30'd1173488,  30'd1099582,   30'd1032444,   30'd971273,    30'd915381,
    30'd864179,   30'd817155,    30'd773868,    30'd733932,    30'd697009
  };

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SQ    = 8'b0000_0010,
    ST_SQRND = 8'b0000_0100,
    ST_MULR  = 8'b0000_1000,
    ST_RNDU  = 8'b0001_0000,
    ST_MULX  = 8'b0010_0000,
    ST_RNDT  = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } sts_state_t;

endpackage

/* sv/sine_taylor_series_core.sv */
// Sine of a Q3.16 angle by a Taylor series on one shared 32 by 32 multiplier.
// The input channel (in_valid, in_stall, in_angle) takes one angle in signed
// Q3.16 radians; angles beyond plus or minus pi are clamped to that bound.
// The result channel (out_valid, out_stall, out_sine_value) returns the sine
// in signed Q2.16, clamped to plus or minus one, one result per transaction.
// A transaction is accepted when valid is high and stall is low.
// Each further term of the series takes four steps on the shared multiplier:
// multiply by the reciprocal, round, multiply by the squared angle, round and
// accumulate. With N = min(TERM_COUNT - 1, 39) further terms, the result is
// registered in the final step after the last of the N terms, and the next
// angle can be taken once the sequencer is back in idle.
// The input side stalls for the whole computation of an item.
// While the receiver stalls, the result register holds its value; a finished
// computation then waits in its last step until the register is free, but a
// new angle may be accepted while the previous result is still waiting.
// Synchronous active-low reset returns the sequencer to idle and empties the
// result register; no other state survives between items.
`timescale 1ns / 1ps
`include "sine_taylor_series_core_defines.svh"

module sine_taylor_series_core
  import sts_pkg::*;
#(
  parameter int TERM_COUNT = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [ANGLE_W-1:0] in_angle,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [SINE_W-1:0] out_sine_value
);

  localparam int ITER_COUNT = (TERM_COUNT - 1 < RECIP_ENTRIES - 1) ?
                              (TERM_COUNT - 1) : (RECIP_ENTRIES - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ITER_COUNT);
  localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

  sts_state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [SINE_W-1:0] out_sine_r;
  logic neg_r;
  logic [MAG_W-1:0] a_r;
  logic [TERM_W-1:0] x2_r;
  logic [TERM_W-1:0] t_r;
  logic [TERM_W-1:0] u_r;
  logic signed [SUM_W-1:0] s_r;
  logic [PROD_W-1:0] prod_r;

  logic in_take;
  logic signed [ANGLE_W-1:0] ang_sat;
  logic [ANGLE_W-1:0] ang_abs;
  logic [TERM_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] product;
  logic [PROD_W-1:0] sq_rnd, u_rnd, t_rnd;
  logic [TERM_W-1:0] t_new;
  logic s_neg;
  logic [SUM_W-1:0] s_abs, s_rnd;
  logic [21:0] mag_full;
  logic [16:0] mag_sat;
  logic [SINE_W-1:0] mag_ext;
  logic fin_go;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_sine_value = out_sine_r;
  assign fin_go = (state_r == ST_FIN) && !(out_valid_r && out_stall);

  always_comb begin
    if (in_angle > PI_Q16) begin
      ang_sat = PI_Q16;
    end else if (in_angle < -PI_Q16) begin
      ang_sat = -PI_Q16;
    end else begin
      ang_sat = in_angle;
    end
    ang_abs = ang_sat[ANGLE_W-1] ? ANGLE_W'(-ang_sat) : ANGLE_W'(ang_sat);
  end

  always_comb begin
    case (state_r)
      ST_SQ: begin
        mul_a = TERM_W'(a_r);
        mul_b = TERM_W'(a_r);
      end
      ST_MULR: begin
        mul_a = t_r;
        mul_b = TERM_W'(RECIP_TABLE[idx_r]);
      end
      ST_MULX: begin
        mul_a = u_r;
        mul_b = x2_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign sq_rnd = prod_r + PROD_W'(8);
  assign u_rnd = prod_r + (PROD_W'(1) << 31);
  assign t_rnd = prod_r + (PROD_W'(1) << 27);
  assign t_new = t_rnd[TERM_W+27:28];

  always_comb begin
    s_neg = s_r[SUM_W-1];
    s_abs = s_neg ? SUM_W'(-s_r) : SUM_W'(s_r);
    s_rnd = s_abs + SUM_W'(2048);
    mag_full = s_rnd[SUM_W-1:12];
    mag_sat = (mag_full > 22'(ONE_Q16)) ? ONE_Q16 : mag_full[16:0];
    mag_ext = SINE_W'(mag_sat);
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_SQ;
          idx_nxt = FIRST_IDX;
        end
      end
      ST_SQ: state_nxt = ST_SQRND;
      ST_SQRND: state_nxt = ST_MULR;
      ST_MULR: state_nxt = ST_RNDU;
      ST_RNDU: state_nxt = ST_MULX;
      ST_MULX: state_nxt = ST_RNDT;
      ST_RNDT: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_MULR;
          idx_nxt = idx_r + FIRST_IDX;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r <= FIRST_IDX;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      neg_r <= ang_sat[ANGLE_W-1];
      a_r <= ang_abs[MAG_W-1:0];
    end
    if (state_r == ST_SQ || state_r == ST_MULR || state_r == ST_MULX) begin
      prod_r <= product;
    end
    if (state_r == ST_SQRND) begin
      x2_r <= sq_rnd[TERM_W+3:4];
      t_r <= TERM_W'(a_r) << 12;
      s_r <= SUM_W'(a_r) << 12;
    end
    if (state_r == ST_RNDU) begin
      u_r <= u_rnd[PROD_W-1:32];
    end
    if (state_r == ST_RNDT) begin
      t_r <= t_new;
      if (idx_r[0]) begin
        s_r <= s_r - $signed(SUM_W'(t_new));
      end else begin
        s_r <= s_r + $signed(SUM_W'(t_new));
      end
    end
    if (fin_go) begin
      out_sine_r <= (s_neg ^ neg_r) ? $signed(-mag_ext) : $signed(mag_ext);
    end
  end

  `STS_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_r == ST_SQ, "accept did not start the series")
  `STS_ASSERT_NEXT(a_fin_delivers, state_r == ST_FIN && !(out_valid && out_stall), out_valid && state_r == ST_IDLE, "finished item not delivered")
  `STS_ASSERT_NOW(a_idx_range, 1'b1, idx_r >= FIRST_IDX && idx_r <= LAST_IDX, "term index out of range")
  `STS_ASSERT_NOW(a_out_range, out_valid, out_sine_value <= 18'sd65536 && out_sine_value >= -18'sd65536, "sine out of range")

endmodule

/* verif/tb_sine_taylor_series_core.sv */
// Testbench for the sine Taylor series core: queued angles, in-bench sine predictor, result check.
`timescale 1ns / 1ps

module tb_sine_taylor_series_core;
  import sts_pkg::*;

  localparam int TERM_COUNT = 10;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 180;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [ANGLE_W-1:0] in_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SINE_W-1:0] out_sine_value;

  logic signed [ANGLE_W-1:0] angle_q[$];
  logic signed [SINE_W-1:0] expected_sine_q[$];
  logic in_took = 1'b0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int mismatches = 0;
  int angles_taken = 0;
  int sines_checked = 0;

  sine_taylor_series_core #(
    .TERM_COUNT(TERM_COUNT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_angle(in_angle),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sine_value(out_sine_value)
  );

  always #5 clk = ~clk;

  // Sums the series on the clamped magnitude and restores the sign at the end.
  function automatic logic signed [SINE_W-1:0] sine_of(input logic signed [ANGLE_W-1:0] angle);
    longint xs;
    longint unsigned mag;
    longint unsigned sq;
    longint unsigned term;
    longint unsigned part;
    longint unsigned den;
    longint unsigned recip;
    longint acc;
    longint r;
    bit neg;
    xs = angle;
    if (xs > PI_Q16) xs = PI_Q16;
    if (xs < -PI_Q16) xs = -PI_Q16;
    neg = xs < 0;
    mag = neg ? -xs : xs;
    sq = (mag * mag + 8) >> 4;
    term = mag << 12;
    acc = term;
    for (int k = 1; k < TERM_COUNT && k < RECIP_ENTRIES; k++) begin
      den = (2 * k) * (2 * k + 1);
      recip = ((64'd1 << 32) + den / 2) / den;
      part = (term * recip + (64'd1 << 31)) >> 32;
      term = (part * sq + (64'd1 << 27)) >> 28;
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc >= 0) begin
      r = (acc + 2048) >>> 12;
    end else begin
      r = -((-acc + 2048) >>> 12);
    end
    if (r > longint'(ONE_Q16)) r = longint'(ONE_Q16);
    if (r < -longint'(ONE_Q16)) r = -longint'(ONE_Q16);
    if (neg) r = -r;
    return r[SINE_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Input driver: offers the next queued angle once the current transaction is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (angle_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_valid <= 1'b1;
        in_angle <= angle_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random, or a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: predicts on each accepted angle and checks each accepted sine.
  always @(posedge clk) begin
    if (rst_n) begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        expected_sine_q.push_back(sine_of(in_angle));
        angles_taken++;
      end
      if (out_valid && !out_stall) begin
        if (expected_sine_q.size() == 0) begin
          report_mismatch($sformatf("unexpected sine %0d", out_sine_value));
        end else begin
          if (out_sine_value !== expected_sine_q[0]) begin
            report_mismatch($sformatf("sine_value got %0d expected %0d",
                                      out_sine_value, expected_sine_q[0]));
          end
          void'(expected_sine_q.pop_front());
          sines_checked++;
        end
      end
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (angle_q.size() > 0 || in_valid || expected_sine_q.size() > 0) @(negedge clk);
  endtask

  task automatic queue_random(input int count);
    int pick;
    int a;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        a = $urandom;
      end else if (pick == 1) begin
        a = int'($urandom_range(64)) + 205887 - 32;
        if ($urandom_range(1)) a = -a;
      end else begin
        a = int'($urandom_range(411774)) - 205887;
      end
      angle_q.push_back(a[ANGLE_W-1:0]);
    end
  endtask

  initial begin
    int phase_idle[4];
    int phase_stall[4];
    phase_idle = '{0, 67, 0, 20};
    phase_stall = '{0, 0, 67, 20};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Zero, tiny angles, the bounds at and beyond pi, the 19-bit extremes, near pi/2.
    angle_q.push_back(19'sd0);
    angle_q.push_back(19'sd1);
    angle_q.push_back(-19'sd1);
    angle_q.push_back(19'sd2);
    angle_q.push_back(19'sd100);
    angle_q.push_back(PI_Q16);
    angle_q.push_back(-PI_Q16);
    angle_q.push_back(PI_Q16 - 19'sd1);
    angle_q.push_back(-PI_Q16 + 19'sd1);
    angle_q.push_back(PI_Q16 + 19'sd1);
    angle_q.push_back(-PI_Q16 - 19'sd1);
    angle_q.push_back(19'sd262143);
    angle_q.push_back(-19'sd262143 - 19'sd1);
    angle_q.push_back(19'sd102943);
    angle_q.push_back(19'sd102944);
    angle_q.push_back(19'sd102945);
    angle_q.push_back(-19'sd102944);
    angle_q.push_back(19'sd34315);
    angle_q.push_back(-19'sd171573);
    angle_q.push_back(19'sd174762);
    angle_q.push_back(-19'sd87381);
    angle_q.push_back(19'sd65536);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      queue_random(PHASE_ITEMS);
      wait_drained();
      repeat (20) @(negedge clk);
    end

    // The receiver holds off while angles keep coming, so the core backs up.
    idle_pct = 0;
    stall_pct = 0;
    hold_req++;
    queue_random(60);
    wait_drained();

    repeat (4 * TERM_COUNT + 20) @(posedge clk);
    if (expected_sine_q.size() != 0) report_mismatch("sines still expected at end");
    $display("Checked %0d sines from %0d angles over directed, idle/stall and hold-off phases.",
             sines_checked, angles_taken);
    if (mismatches == 0) begin
      $display("PASS sine_taylor_series_core");
    end else begin
      $display("FAIL sine_taylor_series_core");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL sine_taylor_series_core");
    $finish;
  end

endmodule
